// ===== rtl/kss_pkg.sv =====
// kss_pkg: constants, codes and the stage record for the knot span search block
// no dependencies; imported by kss_cell and knot_span_search_top
`timescale 1ns / 1ps

package kss_pkg;

  localparam int MAX_KNOTS = 64;
  localparam int COORD_W   = 32;
  localparam int IDX_W     = $clog2(MAX_KNOTS);
  localparam int CNT_W     = $clog2(MAX_KNOTS + 1);
  localparam int KIDX_W    = 6;
  localparam int KC_W      = 7;
  localparam int TOL_W     = 16;
  localparam int SPAN_W    = 7;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KNOT_COUNT = 1'b0,
    CFG_TOLERANCE  = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

  typedef struct packed {
    logic                      valid;
    logic                      is_query;
    logic                      wr;
    logic [IDX_W-1:0]          idx;
    logic signed [COORD_W-1:0] coord;
    logic [CNT_W-1:0]          le_cnt;
    logic [CNT_W-1:0]          lt_cnt;
    logic                      ge_first;
    logic                      le_last;
    logic                      at_last;
  } stage_t;

endpackage

// ===== rtl/knot_span_search_top.sv =====
// knot_span_search_top: chain of knot cells with configuration registers and result stage
// depends on kss_pkg and kss_cell
`timescale 1ns / 1ps

// Every item (knot load or span query) walks the chain of MAX_KNOTS cells, one cell per
// cycle, and its result is on the result ports once it has passed the last cell register and
// the result register, strobed by out_valid for exactly one cycle and taken at the edge that
// ends that cycle; the receiver cannot stall it.
// A new item may start in every cycle, so busy stays low; results come back in start order,
// and a load is seen by every query started after it. Loads return an all-zero result.
// Configuration writes are taken at once (cfg_ready is always high) and must only be made
// while no item is in the chain. There is no clearing pass after reset.

module knot_span_search_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_action,
  input  logic [kss_pkg::KIDX_W-1:0]     in_knot_index,
  input  logic signed [kss_pkg::COORD_W-1:0] in_knot_value,
  input  logic signed [kss_pkg::COORD_W-1:0] in_query_coord,
  output logic                           out_valid,
  output logic signed [kss_pkg::SPAN_W-1:0] out_span_index,
  output logic                           out_in_range,
  output logic                           out_at_last_knot,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [kss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kss_pkg::CFG_W-1:0]      cfg_data
);
  import kss_pkg::*;

  logic [KC_W-1:0]          knot_count_r, knot_count_nxt;
  logic [TOL_W-1:0]         tol_r, tol_nxt;
  logic [CNT_W+KC_W-1:0]    n_used;
  logic [CNT_W+KC_W-1:0]    n_last_w;
  logic [IDX_W-1:0]         last_idx;
  logic [IDX_W+KIDX_W-1:0]  idx_w;
  stage_t                   chain [MAX_KNOTS+1];
  stage_t                   head;
  logic [CNT_W-1:0]         cnt;
  logic [CNT_W+SPAN_W-1:0]  span_w;

  logic                     out_valid_r, out_valid_nxt;
  logic [SPAN_W-1:0]        span_r, span_nxt;
  logic                     in_range_r, in_range_nxt;
  logic                     at_last_r, at_last_nxt;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_comb begin
    knot_count_nxt = knot_count_r;
    tol_nxt        = tol_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_KNOT_COUNT: knot_count_nxt = cfg_data[KC_W-1:0];
        CFG_TOLERANCE:  tol_nxt        = cfg_data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      knot_count_r <= KC_W'(1);
      tol_r        <= TOL_W'(1);
    end else begin
      knot_count_r <= knot_count_nxt;
      tol_r        <= tol_nxt;
    end
  end

  // clamp the knot count to 1..MAX_KNOTS
  always_comb begin
    priority if (knot_count_r == '0) begin
      n_used = (CNT_W+KC_W)'(1);
    end else if ((CNT_W+KC_W)'(knot_count_r) > (CNT_W+KC_W)'(MAX_KNOTS)) begin
      n_used = (CNT_W+KC_W)'(MAX_KNOTS);
    end else begin
      n_used = (CNT_W+KC_W)'(knot_count_r);
    end
  end

  assign n_last_w = n_used - (CNT_W+KC_W)'(1);
  assign last_idx = n_last_w[IDX_W-1:0];
  assign idx_w    = (IDX_W+KIDX_W)'(in_knot_index);

  // chain head
  always_comb begin
    head          = '0;
    head.valid    = start && !busy;
    head.is_query = (action_t'(in_action) == ACT_QUERY);
    head.wr       = ((IDX_W+KIDX_W+1)'(in_knot_index) < (IDX_W+KIDX_W+1)'(MAX_KNOTS));
    head.idx      = idx_w[IDX_W-1:0];
    head.coord    = head.is_query ? in_query_coord : in_knot_value;
  end

  assign chain[0] = head;

  for (genvar g = 0; g < MAX_KNOTS; g++) begin : g_cell
    kss_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (IDX_W'(g)),
      .last_idx  (last_idx),
      .tol       (tol_r),
      .stage_in  (chain[g]),
      .stage_out (chain[g+1])
    );
  end

  // result stage
  assign cnt    = chain[MAX_KNOTS].at_last ? chain[MAX_KNOTS].lt_cnt : chain[MAX_KNOTS].le_cnt;
  assign span_w = (CNT_W+SPAN_W)'(cnt) - (CNT_W+SPAN_W)'(1);

  always_comb begin
    out_valid_nxt = chain[MAX_KNOTS].valid;
    span_nxt      = '0;
    in_range_nxt  = 1'b0;
    at_last_nxt   = 1'b0;
    if (chain[MAX_KNOTS].is_query) begin
      span_nxt     = span_w[SPAN_W-1:0];
      in_range_nxt = chain[MAX_KNOTS].ge_first && chain[MAX_KNOTS].le_last;
      at_last_nxt  = chain[MAX_KNOTS].at_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    span_r     <= span_nxt;
    in_range_r <= in_range_nxt;
    at_last_r  <= at_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_span_index   = span_r;
  assign out_in_range     = in_range_r;
  assign out_at_last_knot = at_last_r;

endmodule

// ===== rtl/kss_cell.sv =====
// kss_cell: one cell of the knot chain, holds one knot and compares passing queries
// depends on kss_pkg
`timescale 1ns / 1ps

module kss_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [kss_pkg::IDX_W-1:0] cell_idx,
  input  logic [kss_pkg::IDX_W-1:0] last_idx,
  input  logic [kss_pkg::TOL_W-1:0] tol,
  input  kss_pkg::stage_t          stage_in,
  output kss_pkg::stage_t          stage_out
);
  import kss_pkg::*;

  logic signed [COORD_W-1:0] knot_r, knot_nxt;
  stage_t                    stage_r, stage_nxt;
  logic                      active;
  logic                      u_lt_k, k_lt_u;
  logic signed [COORD_W:0]   diff;
  logic [COORD_W:0]          mag;
  logic                      near;
  logic                      hit_wr;

  assign active = (cell_idx <= last_idx);
  assign u_lt_k = (stage_in.coord < knot_r);
  assign k_lt_u = (knot_r < stage_in.coord);
  assign diff   = {stage_in.coord[COORD_W-1], stage_in.coord} - {knot_r[COORD_W-1], knot_r};
  assign mag    = diff[COORD_W] ? (COORD_W+1)'(-diff) : (COORD_W+1)'(diff);
  assign near   = (mag < (COORD_W+1)'(tol));
  assign hit_wr = stage_in.valid && !stage_in.is_query && stage_in.wr
                  && (stage_in.idx == cell_idx);

  always_comb begin
    knot_nxt = knot_r;
    if (hit_wr) begin
      knot_nxt = stage_in.coord;
    end
  end

  always_comb begin
    stage_nxt = stage_in;
    if (stage_in.is_query && active) begin
      stage_nxt.le_cnt = stage_in.le_cnt + CNT_W'(!u_lt_k);
      stage_nxt.lt_cnt = stage_in.lt_cnt + CNT_W'(k_lt_u);
    end
    if (stage_in.is_query && (cell_idx == '0)) begin
      stage_nxt.ge_first = !u_lt_k;
    end
    if (stage_in.is_query && (cell_idx == last_idx)) begin
      stage_nxt.le_last = !k_lt_u;
      stage_nxt.at_last = near;
    end
  end

  always_ff @(posedge clk) begin
    knot_r <= knot_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else begin
      stage_r.valid <= stage_nxt.valid;
    end
    stage_r.is_query <= stage_nxt.is_query;
    stage_r.wr       <= stage_nxt.wr;
    stage_r.idx      <= stage_nxt.idx;
    stage_r.coord    <= stage_nxt.coord;
    stage_r.le_cnt   <= stage_nxt.le_cnt;
    stage_r.lt_cnt   <= stage_nxt.lt_cnt;
    stage_r.ge_first <= stage_nxt.ge_first;
    stage_r.le_last  <= stage_nxt.le_last;
    stage_r.at_last  <= stage_nxt.at_last;
  end

  assign stage_out = stage_r;

  a_advance : assert property (@(posedge clk) disable iff (!rst_n)
    stage_in.valid |=> stage_r.valid)
    else $error("item lost in cell");

  a_count_order : assert property (@(posedge clk) disable iff (!rst_n)
    (stage_r.valid && stage_r.is_query) |-> (stage_r.lt_cnt <= stage_r.le_cnt))
    else $error("strict count exceeds inclusive count");

  a_knot_write : assert property (@(posedge clk) disable iff (!rst_n)
    hit_wr |=> (knot_r == $past(stage_in.coord)))
    else $error("knot load not stored");

endmodule
